/* design/ttd_pkg.sv */
// ttd_pkg: shared constants, entry type and tree geometry helpers
// for the tag tree decoder; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ttd_pkg;
  localparam int MAX_GRID = 64;
  localparam int NODE_COUNT_DEF = 5461;
  localparam int POS_W = 6;
  localparam int DIM_W = 7;
  localparam int VAL_W = 16;
  localparam int LVL_W = 3;
  localparam int MAX_LVL = 7;
  localparam int OFF_W = 14;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_QUERY = 2'd1;
  localparam logic [1:0] ACT_BIT = 2'd2;

  typedef struct packed {
    logic             known;
    logic             closed;
    logic [VAL_W-1:0] value;
  } entry_t;

  // register value clamped to 1..MAX_GRID
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) r = DIM_W'(1);
    else if (d > DIM_W'(MAX_GRID)) r = DIM_W'(MAX_GRID);
    return r;
  endfunction

  // size of one level: ceil(d / 2^lv)
  function automatic logic [DIM_W-1:0] dim_at(input logic [DIM_W-1:0] d,
                                               input logic [LVL_W-1:0] lv);
    logic [DIM_W:0] s;
    s = ({1'b0, d} + ((DIM_W+1)'(1) << lv) - (DIM_W+1)'(1)) >> lv;
    return s[DIM_W-1:0];
  endfunction

  // level of the root
  function automatic logic [LVL_W-1:0] top_of(input logic [DIM_W-1:0] w,
                                              input logic [DIM_W-1:0] h);
    logic [DIM_W-1:0] m;
    logic [LVL_W-1:0] lv;
    m = (w > h) ? w : h;
    lv = '0;
    for (int i = 1; i < MAX_LVL; i++) begin
      if (dim_at(m, LVL_W'(i - 1)) > DIM_W'(1)) lv = LVL_W'(i);
    end
    return lv;
  endfunction
endpackage
`default_nettype wire

/* design/tag_tree_decoder_unit.sv */
// tag_tree_decoder_unit: top level of the tag tree decoder
// depends on ttd_pkg and ttd_mem
`timescale 1ns / 1ps
`default_nettype none
// Decodes a tag tree over a grid of up to 64x64 leaves. Each input word is a
// clear, a query or one stream bit (tuser = action) and returns exactly one
// result word. Node state sits in one single-port-read memory, and a small
// sequencer walks it one tree level at a time, so the block takes one word at
// a time. A query first builds the level offsets (one multiply per level),
// then reads and evaluates each level walked and posts the result. A stream
// bit resumes the walk: it updates and evaluates the waiting node, then reads
// and evaluates each further level. A clear sweeps the whole node memory,
// then builds the level offsets to find the root, marks it known and posts.
// The same sweep runs after reset, during which no word is accepted (cfg
// writes still are).
module tag_tree_decoder_unit #(
  parameter int NODE_COUNT = ttd_pkg::NODE_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: pos_x[5:0], pos_y[11:6], limit[27:12], bit_in[28], zero[31:29]
  input  wire logic [31:0] in_tdata,
  // in_tuser: action[1:0]
  input  wire logic [1:0]  in_tuser,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata: result_value[15:0]
  output logic [15:0]      out_tdata,
  // out_tuser: need_bit[0], done_res[1]
  output logic [1:0]       out_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import ttd_pkg::*;

  localparam int AW = $clog2(NODE_COUNT);

  typedef enum logic [2:0] {S_IDLE, S_CLR, S_PREP, S_RD, S_EVAL, S_OUT, S_ROOT} state_t;

  state_t state_r;
  logic [DIM_W-1:0] gw_r, gh_r;
  logic [POS_W-1:0] qx_r, qy_r;
  logic [VAL_W-1:0] lim_r, pv_r, cur_val_r;
  logic cur_cls_r, busy_r, use_cur_r, clr_reply_r;
  logic [LVL_W-1:0] lvl_r, k_r;
  logic [OFF_W-1:0] off_r [MAX_LVL];
  logic [AW-1:0] node_r, clr_addr_r;
  logic res_need_r, res_done_r;
  logic [VAL_W-1:0] res_val_r;
  logic out_valid_r, out_need_r, out_done_r;
  logic [VAL_W-1:0] out_val_r;

  // config port
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[1:0] == 2'd0);
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {25'd0, gw_r} : {25'd0, gh_r};

  // input word fields
  logic [POS_W-1:0] f_x, f_y;
  logic [VAL_W-1:0] f_lim;
  logic f_bit, in_acc;
  assign f_x = in_tdata[5:0];
  assign f_y = in_tdata[11:6];
  assign f_lim = in_tdata[27:12];
  assign f_bit = in_tdata[28];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc = in_tvalid && in_tready;

  // geometry
  logic [DIM_W-1:0] ew, eh, lw, lh, kw, kh;
  logic [LVL_W-1:0] top;
  assign ew = eff_dim(gw_r);
  assign eh = eff_dim(gh_r);
  assign top = top_of(ew, eh);
  assign lw = dim_at(ew, lvl_r);
  assign lh = dim_at(eh, lvl_r);
  assign kw = dim_at(ew, k_r);
  assign kh = dim_at(eh, k_r);

  // node address at the current level
  logic [2*DIM_W-1:0] row_base, kprod;
  logic [OFF_W:0] addr_sum;
  logic [AW-1:0] addr_cur;
  assign row_base = (2*DIM_W)'(qy_r >> lvl_r) * (2*DIM_W)'(lw);
  assign kprod = (2*DIM_W)'(kw) * (2*DIM_W)'(kh);
  assign addr_sum = (OFF_W+1)'(off_r[lvl_r]) + (OFF_W+1)'(row_base)
                  + (OFF_W+1)'(qx_r >> lvl_r);
  assign addr_cur = (addr_sum >= (OFF_W+1)'(NODE_COUNT)) ? AW'(NODE_COUNT - 1)
                  : AW'(addr_sum);

  // node evaluation
  entry_t rdata, ent;
  logic is_top, e_abort, e_need;
  logic [VAL_W-1:0] e_val;
  assign ent = use_cur_r ? entry_t'({1'b1, cur_cls_r, cur_val_r}) : rdata;
  assign is_top = (lvl_r >= top);
  assign e_val = ent.known ? ent.value : (is_top ? '0 : pv_r);
  assign e_abort = !ent.known && !is_top && (pv_r >= lim_r);
  assign e_need = !ent.closed && (e_val < lim_r);

  // memory write select
  logic mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t mem_wdata;
  logic bit_acc;
  assign bit_acc = in_acc && (in_tuser == ACT_BIT) && busy_r;
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = node_r;
    mem_wdata = '0;
    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        mem_waddr = clr_addr_r;
      end
      S_ROOT: begin
        // root of the current grid starts known at zero
        mem_we = 1'b1;
        mem_waddr = addr_cur;
        mem_wdata.known = 1'b1;
      end
      S_EVAL: begin
        mem_we = !ent.known && !e_abort;
        mem_wdata = {1'b1, ent.closed, e_val};
      end
      S_IDLE: begin
        mem_we = bit_acc;
        mem_wdata = {1'b1, cur_cls_r | f_bit, f_bit ? cur_val_r : cur_val_r + VAL_W'(1)};
      end
      default: mem_we = 1'b0;
    endcase
  end

  ttd_mem #(.DEPTH(NODE_COUNT), .AW(AW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(addr_cur), .rdata(rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      gw_r <= DIM_W'(1);
      gh_r <= DIM_W'(1);
      busy_r <= 1'b0;
      use_cur_r <= 1'b0;
      clr_reply_r <= 1'b0;
      clr_addr_r <= '0;
      out_valid_r <= 1'b0;
      qx_r <= '0;
      qy_r <= '0;
      lvl_r <= '0;
      k_r <= '0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_OUT) out_valid_r <= 1'b0;
      if (cfg_wr) begin
        if (cfg_paddr[2] == 1'b0) gw_r <= cfg_pwdata[DIM_W-1:0];
        else gh_r <= cfg_pwdata[DIM_W-1:0];
        busy_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            res_need_r <= 1'b0;
            res_done_r <= 1'b0;
            res_val_r <= '0;
            case (in_tuser)
              ACT_CLEAR: begin
                busy_r <= 1'b0;
                qx_r <= '0;
                qy_r <= '0;
                lvl_r <= top;
                k_r <= '0;
                off_r[0] <= '0;
                clr_addr_r <= '0;
                clr_reply_r <= 1'b1;
                state_r <= S_CLR;
              end
              ACT_QUERY: begin
                qx_r <= (7'(f_x) < ew) ? f_x : POS_W'(ew - DIM_W'(1));
                qy_r <= (7'(f_y) < eh) ? f_y : POS_W'(eh - DIM_W'(1));
                lim_r <= f_lim;
                lvl_r <= top;
                k_r <= '0;
                off_r[0] <= '0;
                use_cur_r <= 1'b0;
                busy_r <= 1'b0;
                state_r <= S_PREP;
              end
              default: begin
                if (bit_acc) begin
                  cur_cls_r <= cur_cls_r | f_bit;
                  if (!f_bit) cur_val_r <= cur_val_r + VAL_W'(1);
                  use_cur_r <= 1'b1;
                  state_r <= S_EVAL;
                end else begin
                  state_r <= S_OUT;
                end
              end
            endcase
          end
        end
        S_CLR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == AW'(NODE_COUNT - 1)) begin
            state_r <= clr_reply_r ? S_PREP : S_IDLE;
          end
        end
        S_PREP: begin
          if (k_r >= top) begin
            state_r <= clr_reply_r ? S_ROOT : S_RD;
          end else begin
            off_r[k_r + LVL_W'(1)] <= off_r[k_r] + OFF_W'(kprod);
            k_r <= k_r + LVL_W'(1);
          end
        end
        S_ROOT: begin
          clr_reply_r <= 1'b0;
          state_r <= S_OUT;
        end
        S_RD: begin
          node_r <= addr_cur;
          use_cur_r <= 1'b0;
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          if (e_abort) begin
            busy_r <= 1'b0;
            res_done_r <= 1'b1;
            res_val_r <= lim_r;
            state_r <= S_OUT;
          end else if (e_need) begin
            busy_r <= 1'b1;
            res_need_r <= 1'b1;
            cur_val_r <= e_val;
            cur_cls_r <= ent.closed;
            state_r <= S_OUT;
          end else if (lvl_r == '0) begin
            busy_r <= 1'b0;
            res_done_r <= 1'b1;
            res_val_r <= (e_val < lim_r) ? e_val : lim_r;
            state_r <= S_OUT;
          end else begin
            pv_r <= e_val;
            lvl_r <= lvl_r - LVL_W'(1);
            state_r <= S_RD;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_need_r <= res_need_r;
            out_done_r <= res_done_r;
            out_val_r <= res_val_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_val_r;
  assign out_tuser = {out_done_r, out_need_r};

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready) else $error("accepted a word while working");
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1])) else $error("need and done both set");
  a_need_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL && !e_abort && e_need) |=> busy_r) else $error("bit wait not busy");
  a_clear_writes_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> (mem_we && mem_wdata == '0)) else $error("sweep write wrong");
`endif
endmodule
`default_nettype wire

/* design/ttd_mem.sv */
// ttd_mem: single write, single registered read node memory
// depends on ttd_pkg for the entry type
`timescale 1ns / 1ps
`default_nettype none
module ttd_mem #(
  parameter int DEPTH = ttd_pkg::NODE_COUNT_DEF,
  parameter int AW = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire ttd_pkg::entry_t wdata,
  input  wire logic [AW-1:0]   raddr,
  output ttd_pkg::entry_t      rdata
);
  import ttd_pkg::*;

  entry_t mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
